[rtl/tgs_pkg.sv]
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types and constants for the trilateration grid search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgs_pkg;

  localparam int unsigned CoordInW   = 24;
  localparam int unsigned RangeW     = 23;
  localparam int unsigned PosW       = 12;
  localparam int unsigned NumAnchors = 3;
  localparam int unsigned AnchorIdxW = 2;

  typedef enum logic [1:0] {
    MUL_DX = 2'd0,
    MUL_DY = 2'd1,
    MUL_D  = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic                  load;
    logic                  axis_y;
    logic                  pt_zero;
    logic                  pt_next;
    logic                  sum_clr;
    logic                  mul_en;
    mul_sel_e              mul_sel;
    logic [AnchorIdxW-1:0] anchor;
    logic                  s_load;
    logic                  s_add;
    logic                  div_start;
    logic                  sum_acc;
    logic                  p_take;
    logic                  px_take;
    logic                  hit_set;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic better;
    logic at_max;
  } status_t;

endpackage

`default_nettype wire

[rtl/tgs_if.sv]
// ----------------------------------------------------------------------------
// tgs_in_if / tgs_out_if
// Valid/ready channels carrying anchor sets in and position fixes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgs_in_if;
  import tgs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [CoordInW-1:0] anchor_a_x;
  logic signed [CoordInW-1:0] anchor_a_y;
  logic        [RangeW-1:0]   range_a;
  logic signed [CoordInW-1:0] anchor_b_x;
  logic signed [CoordInW-1:0] anchor_b_y;
  logic        [RangeW-1:0]   range_b;
  logic signed [CoordInW-1:0] anchor_c_x;
  logic signed [CoordInW-1:0] anchor_c_y;
  logic        [RangeW-1:0]   range_c;

  modport source (
    output valid, anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y, range_b,
           anchor_c_x, anchor_c_y, range_c,
    input  ready
  );
  modport sink (
    input  valid, anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y, range_b,
           anchor_c_x, anchor_c_y, range_c,
    output ready
  );
endinterface

interface tgs_out_if;
  import tgs_pkg::*;
  logic            valid;
  logic            ready;
  logic [PosW-1:0] pos_x;
  logic [PosW-1:0] pos_y;
  logic            hit_limit;

  modport source (output valid, pos_x, pos_y, hit_limit, input ready);
  modport sink   (input  valid, pos_x, pos_y, hit_limit, output ready);
endinterface

`default_nettype wire

[rtl/tgs_div.sv]
// ----------------------------------------------------------------------------
// tgs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgs_div #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic [NW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [DW:0]     rem_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = DW'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/tgs_dpath.sv]
// ----------------------------------------------------------------------------
// tgs_dpath
// Anchor registers, shared squarer, divider and error/position registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgs_dpath #(
  parameter int unsigned MAX_COORD = 4095
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire tgs_pkg::cmd_t                   cmd_i,
  output tgs_pkg::status_t                     status_o,
  input  wire logic signed [tgs_pkg::CoordInW*tgs_pkg::NumAnchors-1:0] ax_i,
  input  wire logic signed [tgs_pkg::CoordInW*tgs_pkg::NumAnchors-1:0] ay_i,
  input  wire logic [tgs_pkg::RangeW*tgs_pkg::NumAnchors-1:0]          rng_i,
  output logic [tgs_pkg::PosW-1:0]             pos_x_o,
  output logic [tgs_pkg::PosW-1:0]             pos_y_o,
  output logic                                 hit_o
);

  import tgs_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COORD + 1);
  localparam int unsigned PW  = CW + 8;
  localparam int unsigned DXW = ((PW + 1 > CoordInW) ? PW + 1 : CoordInW) + 1;
  localparam int unsigned MW  = DXW - 1;
  localparam int unsigned SQW = 2 * MW;
  localparam int unsigned SW  = SQW + 1;
  localparam int unsigned EW  = SW + 2;

  logic signed [CoordInW-1:0] ax_q [NumAnchors];
  logic signed [CoordInW-1:0] ay_q [NumAnchors];
  logic        [RangeW-1:0]   d_q  [NumAnchors];
  logic [CW-1:0]  pt_q, p_q, px_q;
  logic [SQW-1:0] prod_q;
  logic [SW-1:0]  s_q;
  logic [EW-1:0]  sum_q, e_q;
  logic           hit_q;
  logic [PosW-1:0] pos_x_q, pos_y_q;
  logic           hit_out_q;

  logic [CW-1:0]           ex, ey;
  logic signed [DXW-1:0]   dx, dy;
  logic [MW-1:0]           mx, my, opa;
  logic [SW-1:0]           diff;
  logic                    div_busy;
  logic [SW-1:0]           quo;

  assign ex = cmd_i.axis_y ? px_q : pt_q;
  assign ey = cmd_i.axis_y ? pt_q : '0;
  assign dx = $signed(DXW'({ex, 8'h00})) - DXW'(ax_q[cmd_i.anchor]);
  assign dy = $signed(DXW'({ey, 8'h00})) - DXW'(ay_q[cmd_i.anchor]);
  assign mx = dx[DXW-1] ? MW'(-dx) : MW'(dx);
  assign my = dy[DXW-1] ? MW'(-dy) : MW'(dy);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DX:  opa = mx;
      MUL_DY:  opa = my;
      default: opa = MW'(d_q[cmd_i.anchor]);
    endcase
  end

  assign diff = (s_q >= SW'(prod_q)) ? s_q - SW'(prod_q) : SW'(prod_q) - s_q;

  tgs_div #(.NW(SW), .DW(RangeW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff),
    .divisor_i  (d_q[cmd_i.anchor]),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NumAnchors; k++) begin
        ax_q[k] <= ax_i[k*CoordInW +: CoordInW];
        ay_q[k] <= ay_i[k*CoordInW +: CoordInW];
        d_q[k]  <= (rng_i[k*RangeW +: RangeW] == '0) ? RangeW'(1)
                                                      : rng_i[k*RangeW +: RangeW];
      end
    end
    if (cmd_i.pt_zero) begin
      pt_q <= '0;
    end else if (cmd_i.pt_next) begin
      pt_q <= p_q + CW'(1);
    end
    if (cmd_i.mul_en) begin
      prod_q <= opa * opa;
    end
    if (cmd_i.s_load) begin
      s_q <= SW'(prod_q);
    end else if (cmd_i.s_add) begin
      s_q <= s_q + SW'(prod_q);
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + EW'(quo);
    end
    if (cmd_i.p_take) begin
      p_q <= pt_q;
      e_q <= sum_q;
    end
    if (cmd_i.px_take) begin
      px_q <= p_q;
    end
    if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.hit_set) begin
      hit_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      pos_x_q   <= PosW'(px_q);
      pos_y_q   <= PosW'(p_q);
      hit_out_q <= hit_q;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.better   = sum_q < e_q;
  assign status_o.at_max   = 32'(p_q) >= MAX_COORD;

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign hit_o   = hit_out_q;

endmodule

`default_nettype wire

[rtl/tgs_ctrl.sv]
// ----------------------------------------------------------------------------
// tgs_ctrl
// Sequencer for the two axis searches and the per-anchor error terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire tgs_pkg::status_t status_i,
  output tgs_pkg::cmd_t         cmd_o
);

  import tgs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_PT_INIT = 11'b000_0000_0010,
    S_CHECK   = 11'b000_0000_0100,
    S_MX      = 11'b000_0000_1000,
    S_MY      = 11'b000_0001_0000,
    S_MD      = 11'b000_0010_0000,
    S_DIFF    = 11'b000_0100_0000,
    S_DIV     = 11'b000_1000_0000,
    S_EVAL    = 11'b001_0000_0000,
    S_FIN     = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [AnchorIdxW-1:0] k_q, k_d;
  logic                  axis_y_q, axis_y_d;
  logic                  first_q, first_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    axis_y_d    = axis_y_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.axis_y  = axis_y_q;
    cmd_o.anchor  = k_q;
    cmd_o.mul_sel = MUL_DX;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_y_d   = 1'b0;
          state_d    = S_PT_INIT;
        end
      end
      S_PT_INIT: begin
        cmd_o.pt_zero = 1'b1;
        cmd_o.sum_clr = 1'b1;
        k_d           = '0;
        first_d       = 1'b1;
        state_d       = S_MX;
      end
      S_CHECK: begin
        if (status_i.at_max) begin
          cmd_o.hit_set = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.pt_next = 1'b1;
          cmd_o.sum_clr = 1'b1;
          k_d           = '0;
          first_d       = 1'b0;
          state_d       = S_MX;
        end
      end
      S_MX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DX;
        state_d       = S_MY;
      end
      S_MY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DY;
        cmd_o.s_load  = 1'b1;
        state_d       = S_MD;
      end
      S_MD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D;
        cmd_o.s_add   = 1'b1;
        state_d       = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.sum_acc = 1'b1;
          if (32'(k_q) == NumAnchors - 1) begin
            state_d = S_EVAL;
          end else begin
            k_d     = k_q + AnchorIdxW'(1);
            state_d = S_MX;
          end
        end
      end
      S_EVAL: begin
        if (first_q || status_i.better) begin
          cmd_o.p_take = 1'b1;
          state_d      = S_CHECK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!axis_y_q) begin
          cmd_o.px_take = 1'b1;
          axis_y_d      = 1'b1;
          state_d       = S_PT_INIT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      axis_y_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      axis_y_q    <= axis_y_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/trilateration_grid_search.sv]
// ----------------------------------------------------------------------------
// trilateration_grid_search
// 2-D position fix from three ranged anchors by greedy unit-step search.
// ----------------------------------------------------------------------------
// in_i carries three anchors (signed Q16.8) with their ranges (unsigned
// Q15.8); out_o returns pos_x, pos_y (whole units) and hit_limit, one
// transfer per input. One item is processed at a time. Each evaluated grid
// point takes three error terms, computed with the shared squarer and the
// bit-serial restoring divider on an SW-bit dividend (SW = 2*mag width + 1,
// 49 by default). A search visits up to MAX_COORD+1 points per axis.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next finished result waits until the
// held one is transferred. Reset clears the sequencer and output valid; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trilateration_grid_search #(
  parameter int unsigned MAX_COORD = 4095
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tgs_in_if.sink     in_i,
  tgs_out_if.source  out_o
);

  import tgs_pkg::*;

  cmd_t    cmd;
  status_t status;

  tgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tgs_dpath #(.MAX_COORD(MAX_COORD)) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .ax_i     ({in_i.anchor_c_x, in_i.anchor_b_x, in_i.anchor_a_x}),
    .ay_i     ({in_i.anchor_c_y, in_i.anchor_b_y, in_i.anchor_a_y}),
    .rng_i    ({in_i.range_c, in_i.range_b, in_i.range_a}),
    .pos_x_o  (out_o.pos_x),
    .pos_y_o  (out_o.pos_y),
    .hit_o    (out_o.hit_limit)
  );

endmodule

`default_nettype wire
